@@ design/lpht_pkg.sv @@
// Package for the linear-probe hash table core.
// Field widths, status and operation codes, sequencer state type.
// No dependencies.
package lpht_pkg;

	localparam int KEY_W  = 31;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FOUND    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING  = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_MOD   = 4'b0100,
		ST_PROBE = 4'b1000
	} state_t;

endpackage

@@ design/lpht_if.sv @@
// Valid/ready channel interfaces for request and response.
// Depends on lpht_pkg for field widths.
interface lpht_in_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [lpht_pkg::KEY_W-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);
endinterface

interface lpht_out_if;
	logic                        valid;
	logic                        ready;
	logic [lpht_pkg::STAT_W-1:0] status;
	logic [lpht_pkg::KEY_W-1:0]  key_out;
	logic [lpht_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output status, output key_out, output slot, input ready);
	modport sink   (input valid, input status, input key_out, input slot, output ready);
endinterface

@@ design/lpht_mod.sv @@
// Key modulo TABLE_SIZE by reciprocal multiplication, two registered steps.
// Standalone; parameters passed down from the core.
module lpht_mod #(
	parameter int KEY_BITS   = 31,
	parameter int TABLE_SIZE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KEY_BITS-1:0]           key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] rem
);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int SHIFT = KEY_BITS + IDX_W;
	localparam int P_W   = 2 * KEY_BITS + 2;
	// ceil(2^SHIFT / TABLE_SIZE): exact quotient for every KEY_BITS-bit key
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam logic [P_W-1:0]   RECIP_P = P_W'(RECIP);
	localparam logic [IDX_W-1:0] TS_LO   = IDX_W'(TABLE_SIZE);

	logic [KEY_BITS-1:0] key_s1;
	logic                vld_s1;
	logic [IDX_W-1:0]    quo_s2;
	logic                vld_s2;
	logic [P_W-1:0]      prod;
	logic [IDX_W-1:0]    quo_nx;
	logic [IDX_W-1:0]    qt;

	always_comb begin
		prod   = P_W'(key_s1) * RECIP_P;
		quo_nx = IDX_W'(prod >> SHIFT);
		// remainder is below TABLE_SIZE, so the low index bits are enough
		qt     = quo_s2 * TS_LO;
		rem    = IDX_W'(key_s1) - qt;
		done   = vld_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
		end
		if (vld_s1) begin
			quo_s2 <= quo_nx;
		end
	end

endmodule

@@ design/linear_probe_hash_table_core.sv @@
// Linear-probe hash table core: insert / search of keys, one request at a time.
// The home slot comes from the reciprocal multiply in lpht_mod, then slots are probed in
// turn from it (1 to TABLE_SIZE of them) until an empty slot, a match or a full lap.
// A new request is taken once probing of the last one ends; a waiting response stalls probing.
// Reset: asynchronous; a clearing pass over every slot empties the valid store.
// Depends on lpht_pkg, lpht_if, lpht_mod.
module linear_probe_hash_table_core #(
	parameter int TABLE_SIZE = 16,
	parameter int KEY_BITS   = 31
) (
	input  logic clk,
	input  logic arst_n,
	lpht_in_if.sink    req,
	lpht_out_if.source rsp
);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int DIV_W = (KEY_BITS < lpht_pkg::KEY_W) ? KEY_BITS : lpht_pkg::KEY_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

	lpht_pkg::state_t state_q;

	logic                  op_q;
	logic [KEY_BITS-1:0]   k_q;
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      clr_q;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      nxt;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic                  rd_vld_q;

	logic [KEY_BITS-1:0]   key_mem [TABLE_SIZE];
	logic                  vld_mem [TABLE_SIZE];

	logic [KEY_BITS+lpht_pkg::KEY_W-1:0] key_ext;
	logic [KEY_BITS+lpht_pkg::KEY_W-1:0] kout_ext;
	logic [IDX_W+lpht_pkg::SLOT_W-1:0]   slot_ext;
	logic [KEY_BITS-1:0]   k_in;

	logic                  accept;
	logic                  hold;
	logic                  probing;
	logic                  found;
	logic                  lap;
	logic                  finish;
	logic                  ins_we;
	logic                  vld_we;
	logic [IDX_W-1:0]      vld_wa;
	logic                  vld_wd;
	logic [lpht_pkg::STAT_W-1:0] stat_nx;
	logic                  keep;

	logic                  mod_done;
	logic [IDX_W-1:0]      mod_rem;

	logic                        out_vld_q;
	logic [lpht_pkg::STAT_W-1:0] out_stat_q;
	logic [lpht_pkg::KEY_W-1:0]  out_key_q;
	logic [lpht_pkg::SLOT_W-1:0] out_slot_q;

	lpht_mod #(
		.KEY_BITS   (DIV_W),
		.TABLE_SIZE (TABLE_SIZE)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (k_in[DIV_W-1:0]),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_comb begin
		key_ext  = {{KEY_BITS{1'b0}}, req.key};
		k_in     = key_ext[KEY_BITS-1:0];
		req.ready = (state_q == lpht_pkg::ST_IDLE);
		accept   = req.valid && req.ready;
		hold     = out_vld_q && !rsp.ready;
		probing  = (state_q == lpht_pkg::ST_PROBE) && !hold;
		nxt      = (cur_q == LAST) ? '0 : cur_q + IDX_W'(1);
		found    = (op_q == lpht_pkg::OP_SEARCH) && rd_vld_q && (rd_key_q == k_q);
		lap      = (cnt_q == LAST);
		finish   = probing && (!rd_vld_q || found || lap);
		ins_we   = probing && (op_q == lpht_pkg::OP_INSERT) && !rd_vld_q;
		vld_we   = (state_q == lpht_pkg::ST_CLEAR) || ins_we;
		vld_wa   = (state_q == lpht_pkg::ST_CLEAR) ? clr_q : cur_q;
		vld_wd   = (state_q != lpht_pkg::ST_CLEAR);

		if (op_q == lpht_pkg::OP_INSERT) begin
			stat_nx = rd_vld_q ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_INSERTED;
		end else begin
			stat_nx = found ? lpht_pkg::STAT_FOUND : lpht_pkg::STAT_MISSING;
		end
		keep = (stat_nx == lpht_pkg::STAT_INSERTED) || (stat_nx == lpht_pkg::STAT_FOUND);

		kout_ext = {{lpht_pkg::KEY_W{1'b0}}, k_q};
		slot_ext = {{lpht_pkg::SLOT_W{1'b0}}, cur_q};

		case (state_q)
			lpht_pkg::ST_MOD:   rd_addr = mod_rem;
			lpht_pkg::ST_PROBE: rd_addr = hold ? cur_q : nxt;
			default:            rd_addr = cur_q;
		endcase
	end

	// slot memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ins_we) begin
			key_mem[cur_q] <= k_q;
		end
		if (vld_we) begin
			vld_mem[vld_wa] <= vld_wd;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_vld_q <= vld_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lpht_pkg::ST_CLEAR;
			clr_q     <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				lpht_pkg::ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST) begin
						state_q <= lpht_pkg::ST_IDLE;
					end
				end
				lpht_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= lpht_pkg::ST_MOD;
					end
				end
				lpht_pkg::ST_MOD: begin
					if (mod_done) begin
						cnt_q   <= '0;
						state_q <= lpht_pkg::ST_PROBE;
					end
				end
				lpht_pkg::ST_PROBE: begin
					if (finish) begin
						state_q <= lpht_pkg::ST_IDLE;
					end else if (probing) begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				default: state_q <= lpht_pkg::ST_CLEAR;
			endcase

			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.op;
			k_q  <= k_in;
		end
		if ((state_q == lpht_pkg::ST_MOD) && mod_done) begin
			cur_q <= mod_rem;
		end else if (probing && !finish) begin
			cur_q <= nxt;
		end
		if (finish) begin
			out_stat_q <= stat_nx;
			out_key_q  <= keep ? kout_ext[lpht_pkg::KEY_W-1:0] : '0;
			out_slot_q <= keep ? slot_ext[lpht_pkg::SLOT_W-1:0] : '0;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.status  = out_stat_q;
	assign rsp.key_out = out_key_q;
	assign rsp.slot    = out_slot_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lpht_pkg::ST_IDLE) |-> !req.ready)
		else $error("request taken while busy");

	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == lpht_pkg::ST_MOD))
		else $error("modulo unit finished outside its state");

	a_accept_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == lpht_pkg::ST_MOD))
		else $error("accepted request did not start modulo");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == lpht_pkg::STAT_FULL ||
			rsp.status == lpht_pkg::STAT_MISSING)) |-> (rsp.key_out == '0 && rsp.slot == '0))
		else $error("miss or full response carries nonzero fields");

endmodule

@@ test/linear_probe_hash_table_core_test.sv @@
`timescale 1ns / 100ps
// Testbench for linear_probe_hash_table_core: directed and random insert/search requests,
// each response checked against a behavioral copy of the probe table.
// Depends on lpht_pkg, lpht_if and the core.
module linear_probe_hash_table_core_test;

	localparam int TABLE_SIZE   = 16;
	localparam int KEY_BITS     = 31;
	localparam int DRAIN_CYCLES = KEY_BITS + TABLE_SIZE + 8;

	typedef struct packed {
		logic [lpht_pkg::STAT_W-1:0] status;
		logic [lpht_pkg::KEY_W-1:0]  key_out;
		logic [lpht_pkg::SLOT_W-1:0] slot;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	lpht_in_if  req_ch ();
	lpht_out_if rsp_ch ();

	linear_probe_hash_table_core #(
		.TABLE_SIZE(TABLE_SIZE),
		.KEY_BITS  (KEY_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	logic [lpht_pkg::KEY_W-1:0] tbl_key [TABLE_SIZE];
	bit                         tbl_used [TABLE_SIZE];
	int                         used_count;
	logic [lpht_pkg::KEY_W-1:0] stored_keys [$];
	rsp_t                       pending_rsp [$];
	rsp_t                       want_rsp;
	int                         mismatch_count = 0;
	int                         ready_hold = 0;
	bit                         quiet;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Probe from the home slot, one slot per step, wrapping, at most one lap.
	function automatic rsp_t predict_table_op(input logic op,
		input logic [lpht_pkg::KEY_W-1:0] key);
		rsp_t r;
		int   pos;
		r.status  = (op == lpht_pkg::OP_INSERT) ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_MISSING;
		r.key_out = '0;
		r.slot    = '0;
		pos       = int'(key % TABLE_SIZE);
		for (int n = 0; n < TABLE_SIZE; n++) begin
			if (!tbl_used[pos]) begin
				if (op == lpht_pkg::OP_INSERT) begin
					tbl_used[pos] = 1'b1;
					tbl_key[pos]  = key;
					used_count++;
					stored_keys.push_back(key);
					r.status  = lpht_pkg::STAT_INSERTED;
					r.key_out = key;
					r.slot    = lpht_pkg::SLOT_W'(pos);
				end
				return r;
			end
			if (op == lpht_pkg::OP_SEARCH && tbl_key[pos] == key) begin
				r.status  = lpht_pkg::STAT_FOUND;
				r.key_out = key;
				r.slot    = lpht_pkg::SLOT_W'(pos);
				return r;
			end
			pos = (pos + 1) % TABLE_SIZE;
		end
		return r;
	endfunction

	// Optional idle burst placed while the core is ready, then hold the request until taken.
	task automatic issue_request(input logic op, input logic [lpht_pkg::KEY_W-1:0] key);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while (!req_ch.ready);
			repeat (gap - 1) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.key   <= key;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(predict_table_op(op, key));
	endtask

	function automatic logic [lpht_pkg::KEY_W-1:0] pick_stored();
		return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
	endfunction

	task automatic test_empty_table();
		issue_request(lpht_pkg::OP_SEARCH, '0);
		issue_request(lpht_pkg::OP_SEARCH, '1);
	endtask

	task automatic test_extreme_keys();
		issue_request(lpht_pkg::OP_INSERT, '0);
		issue_request(lpht_pkg::OP_INSERT, '1);
		issue_request(lpht_pkg::OP_SEARCH, '0);
		issue_request(lpht_pkg::OP_SEARCH, '1);
		// duplicate lands after a wrap past slot 0
		issue_request(lpht_pkg::OP_INSERT, '1);
		issue_request(lpht_pkg::OP_SEARCH, '1);
	endtask

	task automatic test_collisions();
		issue_request(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(5));
		issue_request(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(21));
		issue_request(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(37));
		issue_request(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'(37));
		// same home, stops at the first empty slot
		issue_request(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'(53));
	endtask

	task automatic test_wraparound();
		issue_request(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(14));
		issue_request(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(30));
		issue_request(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'(30));
		issue_request(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'(46));
	endtask

	// Mostly searches with a trickle of inserts; the table fills part way through.
	task automatic test_random_traffic(input int n_items);
		logic                       op;
		logic [lpht_pkg::KEY_W-1:0] key;
		for (int i = 0; i < n_items; i++) begin
			op  = ($urandom_range(0, (used_count < TABLE_SIZE) ? 29 : 11) == 0) ?
				lpht_pkg::OP_INSERT : lpht_pkg::OP_SEARCH;
			key = lpht_pkg::KEY_W'($urandom);
			case ($urandom_range(0, 3))
				0: ;
				1: if (stored_keys.size() != 0) key = pick_stored();
				2: if (stored_keys.size() != 0) key[3:0] = 4'(pick_stored());
				default: begin
					if (op == lpht_pkg::OP_SEARCH && stored_keys.size() != 0)
						key = pick_stored();
					else
						key[3:0] = 4'($urandom_range(0, 3));
				end
			endcase
			issue_request(op, key);
		end
	endtask

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response: status %0d key_out %0h slot %0d",
					rsp_ch.status, rsp_ch.key_out, rsp_ch.slot);
				mismatch_count++;
			end else begin
				want_rsp = pending_rsp.pop_front();
				if (rsp_ch.status !== want_rsp.status) begin
					$error("status: expected %0d, got %0d", want_rsp.status, rsp_ch.status);
					mismatch_count++;
				end
				if (rsp_ch.key_out !== want_rsp.key_out) begin
					$error("key_out: expected %0h, got %0h", want_rsp.key_out, rsp_ch.key_out);
					mismatch_count++;
				end
				if (rsp_ch.slot !== want_rsp.slot) begin
					$error("slot: expected %0d, got %0d", want_rsp.slot, rsp_ch.slot);
					mismatch_count++;
				end
			end
		end
		if (ready_hold > 0) begin
			ready_hold--;
			rsp_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			ready_hold = $urandom_range(0, 2);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.op      = lpht_pkg::OP_INSERT;
		req_ch.key     = '0;
		used_count     = 0;
		quiet          = 1'b0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tbl_used[i] = 1'b0;
			tbl_key[i]  = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_extreme_keys();
		test_collisions();
		test_wraparound();
		test_random_traffic(950);
		quiet = 1'b1;
		test_random_traffic(150);
		req_ch.valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
design/lpht_pkg.sv
design/lpht_if.sv
design/lpht_mod.sv
design/linear_probe_hash_table_core.sv
test/linear_probe_hash_table_core_test.sv
